// ----- hw/rtl/quadrant_gain_match_event_sum_defines.svh -----
// Assertion macros for the quadrant gain match block.
// Used by the port checker; relies on signals named clock and reset in scope.
`ifndef QUADRANT_GAIN_MATCH_EVENT_SUM_DEFINES_SVH
`define QUADRANT_GAIN_MATCH_EVENT_SUM_DEFINES_SVH

// Clocked check, quiet while reset is high.
`define QGMES_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also runs through reset.
`define QGMES_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hw/rtl/qgmes_pkg.sv -----
// Shared types, constants and helpers for the quadrant gain match block.
// No dependencies; imported by the top level, the coefficient bank and the multiplier.
package qgmes_pkg;

   localparam int NUM_CRYSTALS   = 4;
   localparam int CRYSTAL_SEL_W  = $clog2(NUM_CRYSTALS);
   localparam int MAX_HITS       = 16;
   localparam int COEF_W         = 21;
   localparam int COEF_REG_W     = 3 * COEF_W;
   localparam int ENERGY_W       = 16;
   localparam int SUM_W          = 20;
   localparam int ACC_W          = 60;
   localparam int MUL_B_W        = 33;
   localparam int PROD_W         = COEF_W + MUL_B_W;
   localparam int CSR_INDEX_W    = 8;
   localparam int CSR_DATA_W     = 64;

   // c0 = 0, c1 = 1.0, c2 = 0
   localparam logic [COEF_REG_W-1:0] COEF_RESET = 63'd549755813888;

   localparam logic signed [SUM_W-1:0] SUM_MAX = 20'sh7FFFF;
   localparam logic signed [SUM_W-1:0] SUM_MIN = 20'sh80000;

   // Shared multiply/accumulate unit operations
   localparam logic [2:0] MAC_HOLD  = 3'd0;
   localparam logic [2:0] MAC_LOAD  = 3'd1;
   localparam logic [2:0] MAC_EE    = 3'd2;
   localparam logic [2:0] MAC_C2    = 3'd3;
   localparam logic [2:0] MAC_C1    = 3'd4;
   localparam logic [2:0] MAC_ADD18 = 3'd5;

   typedef struct packed {
      logic signed [COEF_W-1:0] c2;
      logic signed [COEF_W-1:0] c1;
      logic signed [COEF_W-1:0] c0;
   } coef_type;

   typedef struct packed {
      logic [2:0]          op;
      logic [ENERGY_W-1:0] energy;
      coef_type            coef;
   } mac_ctrl_type;

   // Saturate a 24-bit signed value to the 20-bit signed range.
   function automatic logic signed [SUM_W-1:0] sat20(input logic signed [23:0] v);
      logic signed [SUM_W-1:0] r;
      if (v > 24'(SUM_MAX)) begin
         r = SUM_MAX;
      end else if (v < 24'(SUM_MIN)) begin
         r = SUM_MIN;
      end else begin
         r = v[SUM_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/quadrant_gain_match_event_sum.sv -----
// Steps for a gained hit: E*E, c2*EE, c1*E, add, commit; a hit with a zero
// coordinate bypasses the gain and goes straight to commit.
// Throughput: a new word is taken only once the sequencer is back in idle, as the
// single shared multiplier is stepped through three products; a stalled result holds commit.
// Reset: synchronous, clears sequencer, event sum, held times and result valid,
// and loads every crystal with the identity gain. No clearing pass is needed.
module quadrant_gain_match_event_sum import qgmes_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   // input word channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [ENERGY_W-1:0]        req_raw_energy,
   input  logic signed [15:0]         req_pos_x,
   input  logic signed [15:0]         req_pos_y,
   input  logic [3:0]                 req_hit_index,
   input  logic [4:0]                 req_hit_count,
   input  logic [31:0]                req_event_stamp,
   input  logic signed [31:0]         req_live_ticks,
   // result word channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SUM_W-1:0]    rsp_total_energy,
   output logic [31:0]                rsp_out_stamp,
   output logic signed [31:0]         rsp_out_live,
   // coefficient write channel
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EE   = 3'd1;
   localparam logic [2:0] S_C2   = 3'd2;
   localparam logic [2:0] S_C1   = 3'd3;
   localparam logic [2:0] S_ADD  = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]               state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0]  energy_sum_ff, energy_sum_in;
   logic [31:0]              held_stamp_ff, held_stamp_in;
   logic signed [31:0]       held_live_ff, held_live_in;

   // word captured at accept
   logic [ENERGY_W-1:0]      energy_ff;
   logic [3:0]               index_ff;
   logic [4:0]               count_ff;
   logic [31:0]              stamp_ff;
   logic signed [31:0]       live_ff;
   logic                     gain_en_ff;

   logic                     req_accept;
   logic                     gain_en;
   logic [CRYSTAL_SEL_W-1:0] crystal_sel;
   coef_type                 coef;
   mac_ctrl_type             mac_ctrl;
   logic signed [SUM_W-1:0]  gain_out;
   logic signed [SUM_W-1:0]  hit_energy;
   logic signed [SUM_W-1:0]  sum_next;
   logic [31:0]              stamp_next;
   logic signed [31:0]       live_next;
   logic                     emit;
   logic                     out_free;
   logic                     commit;

   // the user must write coefficients only while idle (the block does not enforce it), so always take the word
   assign csr_ready = 1'b1;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   // both coordinates nonzero picks a crystal; sign bits give the quadrant
   assign gain_en     = (req_pos_x != '0) && (req_pos_y != '0);
   assign crystal_sel = {~req_pos_y[15], ~req_pos_x[15]};

   qgmes_coef_bank u_coef_bank (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .rd_sel   (crystal_sel),
      .rd_coef  (coef)
   );

   // step the shared unit from the sequencer state
   always_comb begin
      mac_ctrl.energy = req_raw_energy;
      mac_ctrl.coef   = coef;
      unique case (state_ff)
         S_IDLE:  mac_ctrl.op = req_accept ? MAC_LOAD : MAC_HOLD;
         S_EE:    mac_ctrl.op = MAC_EE;
         S_C2:    mac_ctrl.op = MAC_C2;
         S_C1:    mac_ctrl.op = MAC_C1;
         S_ADD:   mac_ctrl.op = MAC_ADD18;
         default: mac_ctrl.op = MAC_HOLD;
      endcase
   end

   qgmes_mac u_mac (
      .clock    (clock),
      .ctrl     (mac_ctrl),
      .gain_out (gain_out)
   );

   // bypass the gain when a coordinate is zero
   assign hit_energy = gain_en_ff ? gain_out
                                  : signed'({{(SUM_W-ENERGY_W){1'b0}}, energy_ff});

   // first hit restarts the sum and takes its own times
   always_comb begin
      if (index_ff == '0) begin
         sum_next   = hit_energy;
         stamp_next = stamp_ff;
         live_next  = live_ff;
      end else begin
         sum_next   = sat20(24'(energy_sum_ff) + 24'(hit_energy));
         stamp_next = held_stamp_ff;
         live_next  = held_live_ff;
      end
   end

   // emit on the last hit of a count that is in range
   assign emit = (count_ff != '0) && (int'(count_ff) <= MAX_HITS)
              && (5'(index_ff) == count_ff - 5'd1);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   // hold the commit of an emitting word while an earlier result still waits
   assign commit   = (state_ff == S_DONE) && (!emit || out_free);

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      energy_sum_in = energy_sum_ff;
      held_stamp_in = held_stamp_ff;
      held_live_in  = held_live_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = gain_en ? S_EE : S_DONE;
            end
         end
         S_EE:  state_in = S_C2;
         S_C2:  state_in = S_C1;
         S_C1:  state_in = S_ADD;
         S_ADD: state_in = S_DONE;
         S_DONE: begin
            if (commit) begin
               state_in      = S_IDLE;
               energy_sum_in = sum_next;
               held_stamp_in = stamp_next;
               held_live_in  = live_next;
               if (emit) begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         energy_sum_ff <= '0;
         held_stamp_ff <= '0;
         held_live_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         energy_sum_ff <= energy_sum_in;
         held_stamp_ff <= held_stamp_in;
         held_live_ff  <= held_live_in;
      end
   end

   // capture the accepted word
   always_ff @(posedge clock) begin
      if (req_accept) begin
         energy_ff  <= req_raw_energy;
         index_ff   <= req_hit_index;
         count_ff   <= req_hit_count;
         stamp_ff   <= req_event_stamp;
         live_ff    <= req_live_ticks;
         gain_en_ff <= gain_en;
      end
   end

   // result register; loads only when free, so a stalled word holds
   always_ff @(posedge clock) begin
      if (commit && emit) begin
         rsp_total_energy <= sum_next;
         rsp_out_stamp    <= stamp_next;
         rsp_out_live     <= live_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hw/rtl/qgmes_coef_bank.sv -----
// Per-crystal gain coefficient registers with one write and one read port.
// Depends on qgmes_pkg.
module qgmes_coef_bank import qgmes_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [CSR_INDEX_W-1:0]   wr_index,
   input  logic [CSR_DATA_W-1:0]    wr_data,
   input  logic [CRYSTAL_SEL_W-1:0] rd_sel,
   output coef_type                 rd_coef
);

   logic [COEF_REG_W-1:0] coef_ff [NUM_CRYSTALS];
   logic                  wr_hit;

   // drop writes past the last crystal
   assign wr_hit = wr_en && (wr_index < CSR_INDEX_W'(NUM_CRYSTALS));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CRYSTALS; i++) begin
            coef_ff[i] <= COEF_RESET;
         end
      end else if (wr_hit) begin
         coef_ff[wr_index[CRYSTAL_SEL_W-1:0]] <= wr_data[COEF_REG_W-1:0];
      end
   end

   assign rd_coef = coef_type'(coef_ff[rd_sel]);

endmodule

// ----- hw/rtl/qgmes_mac.sv -----
// Shared multiplier and wide accumulator for the quadratic gain.
// Depends on qgmes_pkg; stepped by the sequencer in the top level.
module qgmes_mac import qgmes_pkg::*; (
   input  logic                    clock,
   input  mac_ctrl_type            ctrl,
   output logic signed [SUM_W-1:0] gain_out
);

   logic [ENERGY_W-1:0]       energy_ff, energy_in;
   logic signed [COEF_W-1:0]  c1_ff, c1_in;
   logic signed [COEF_W-1:0]  c2_ff, c2_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [COEF_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_p;
   logic signed [ACC_W-1:0]   prod_ext;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (ctrl.op)
         MAC_EE: begin
            mul_a = signed'({{(COEF_W-ENERGY_W){1'b0}}, energy_ff});
            mul_b = signed'({{(MUL_B_W-ENERGY_W){1'b0}}, energy_ff});
         end
         MAC_C2: begin
            mul_a = c2_ff;
            mul_b = signed'({1'b0, prod_ff[2*ENERGY_W-1:0]});
         end
         MAC_C1: begin
            mul_a = c1_ff;
            mul_b = signed'({{(MUL_B_W-ENERGY_W){1'b0}}, energy_ff});
         end
         default: begin
         end
      endcase
   end

   assign mul_p    = mul_a * mul_b;
   assign prod_ext = ACC_W'(prod_ff);

   always_comb begin
      energy_in = energy_ff;
      c1_in     = c1_ff;
      c2_in     = c2_ff;
      prod_in   = prod_ff;
      acc_in    = acc_ff;
      unique case (ctrl.op)
         MAC_LOAD: begin
            energy_in = ctrl.energy;
            c1_in     = ctrl.coef.c1;
            c2_in     = ctrl.coef.c2;
            // c0 * 2^36 plus the rounding half, no adder needed
            acc_in    = signed'({{(ACC_W-COEF_W-36){ctrl.coef.c0[COEF_W-1]}},
                                 ctrl.coef.c0, 1'b1, 35'b0});
         end
         MAC_EE, MAC_C2: begin
            prod_in = mul_p;
         end
         MAC_C1: begin
            prod_in = mul_p;
            acc_in  = acc_ff + prod_ext;
         end
         MAC_ADD18: begin
            acc_in = acc_ff + (prod_ext <<< 18);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      energy_ff <= energy_in;
      c1_ff     <= c1_in;
      c2_ff     <= c2_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
   end

   // floor by 2^36 is an arithmetic shift; the half is already in
   assign gain_out = sat20(signed'(acc_ff[ACC_W-1:36]));

endmodule

// ----- hw/rtl/qgmes_checker.sv -----
// Port-level checker for the quadrant gain match block, bound to the top level.
// Depends on quadrant_gain_match_event_sum_defines.svh.
`include "quadrant_gain_match_event_sum_defines.svh"

module qgmes_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [19:0] rsp_total_energy,
   input logic [31:0]        rsp_out_stamp,
   input logic signed [31:0] rsp_out_live
);

   // a stalled result word holds
   `QGMES_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_total_energy) && $stable(rsp_out_stamp) && $stable(rsp_out_live), "result word changed while stalled")

   // an accepted word keeps the block busy for at least the next cycle
   `QGMES_ASSERT(a_busy_after_accept, req_valid && !req_stall |=> req_stall, "accepted a second word back to back")

   // a new result only comes out of a busy sequencer
   `QGMES_ASSERT(a_rsp_from_busy, $rose(rsp_valid) |-> $past(req_stall), "result appeared without an item in work")

   // reset leaves no result pending and the input open
   `QGMES_ASSERT_RST(a_reset_clear, reset |=> !rsp_valid && !req_stall, "reset did not clear the block")

endmodule

bind quadrant_gain_match_event_sum qgmes_checker u_qgmes_checker (.*);

// ----- test/tb.sv -----
// Self-checking bench for quadrant_gain_match_event_sum: drives interaction words,
// predicts gain-matched event totals in a scoreboard class and checks every result.
// Depends on qgmes_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb;
   import qgmes_pkg::*;

   localparam int NUM_PHASES   = 8;
   localparam int PHASE_HITS   = 155;
   localparam int DRAIN_CYCLES = 16;    // covers the gained latency
   localparam int STALL_LIMIT  = 2000;  // cycles with no word moving on any channel

   // Register map: crystals sit at the bottom, everything above is unused
   localparam logic [CSR_INDEX_W-1:0] REG_CRYSTAL_FIRST = 8'd0;
   localparam int                     REG_UNUSED_FIRST  = NUM_CRYSTALS;
   localparam int                     REG_LAST          = 255;

   // Crystal picked by the signs of x and y; NONE means a zero coordinate
   typedef enum int {
      CRYSTAL_XN_YN = 0,
      CRYSTAL_XP_YN = 1,
      CRYSTAL_XN_YP = 2,
      CRYSTAL_XP_YP = 3,
      CRYSTAL_NONE  = 4
   } crystal_type;

   typedef enum int {
      COEF_MAX, COEF_MIN, COEF_ZERO, COEF_UNITY, COEF_WILD, COEF_MIXED
   } coef_kind_type;

   typedef struct {
      logic signed [SUM_W-1:0] total;
      logic [31:0]             stamp;
      logic signed [31:0]      live;
   } event_total_type;

   // Running event sum with its own copy of the coefficient registers
   class event_total_tracker;
      coef_type                crystal [NUM_CRYSTALS];
      logic signed [SUM_W-1:0] running_sum;
      logic [31:0]             held_stamp;
      logic signed [31:0]      held_live;
      event_total_type         awaited_totals [$];
      int                      failures;

      function new();
         foreach (crystal[i]) crystal[i] = COEF_RESET;
         running_sum = '0;
         held_stamp  = '0;
         held_live   = '0;
         failures    = 0;
      endfunction

      function void write_coeff(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         if (index < NUM_CRYSTALS)
            crystal[index[CRYSTAL_SEL_W-1:0]] = data[COEF_REG_W-1:0];
      endfunction

      function logic signed [SUM_W-1:0] clamp_sum(longint v);
         if (v > longint'(SUM_MAX)) return SUM_MAX;
         if (v < longint'(SUM_MIN)) return SUM_MIN;
         return SUM_W'(v);
      endfunction

      function crystal_type quadrant(logic signed [15:0] x, logic signed [15:0] y);
         if (x < 0 && y < 0) return CRYSTAL_XN_YN;
         if (x > 0 && y < 0) return CRYSTAL_XP_YN;
         if (x < 0 && y > 0) return CRYSTAL_XN_YP;
         if (x > 0 && y > 0) return CRYSTAL_XP_YP;
         return CRYSTAL_NONE;
      endfunction

      // (c0*2^36 + c1*E*2^18 + c2*E*E + 2^35) >> 36, halves round up
      function logic signed [SUM_W-1:0] gain_matched(crystal_type which, logic [15:0] energy);
         coef_type c;
         longint   ee;
         longint   acc;
         if (which == CRYSTAL_NONE) return $signed({4'b0000, energy});
         c   = crystal[CRYSTAL_SEL_W'(which)];
         ee  = longint'(energy);
         acc = (longint'(c.c0) <<< 36) + ((longint'(c.c1) * ee) <<< 18)
             + longint'(c.c2) * ee * ee + (64'sd1 <<< 35);
         return clamp_sum(acc >>> 36);
      endfunction

      function void note_hit(logic [15:0] energy, logic signed [15:0] x,
                             logic signed [15:0] y, logic [3:0] index, logic [4:0] count,
                             logic [31:0] stamp, logic signed [31:0] live);
         logic signed [SUM_W-1:0] gained;
         event_total_type         t;
         gained = gain_matched(quadrant(x, y), energy);
         if (index == 4'd0) begin
            running_sum = gained;
            held_stamp  = stamp;
            held_live   = live;
         end else begin
            running_sum = clamp_sum(longint'(running_sum) + longint'(gained));
         end
         if (count >= 5'd1 && count <= MAX_HITS && {1'b0, index} == count - 5'd1) begin
            t.total = running_sum;
            t.stamp = held_stamp;
            t.live  = held_live;
            awaited_totals.insert(awaited_totals.size(), t);
         end
      endfunction

      function void complain(string what);
         failures++;
         $display("%0t: %s", $time, what);
      endfunction

      function void check_total(logic signed [SUM_W-1:0] total, logic [31:0] stamp,
                                logic signed [31:0] live);
         event_total_type want;
         if (awaited_totals.size() == 0) begin
            complain($sformatf("result with none expected: total %0d stamp %0h live %0d",
                               total, stamp, live));
            return;
         end
         want = awaited_totals.pop_front();
         if (total !== want.total)
            complain($sformatf("total_energy expected %0d got %0d", want.total, total));
         if (stamp !== want.stamp)
            complain($sformatf("out_stamp expected %0h got %0h", want.stamp, stamp));
         if (live !== want.live)
            complain($sformatf("out_live expected %0d got %0d", want.live, live));
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [ENERGY_W-1:0]     req_raw_energy;
   logic signed [15:0]      req_pos_x;
   logic signed [15:0]      req_pos_y;
   logic [3:0]              req_hit_index;
   logic [4:0]              req_hit_count;
   logic [31:0]             req_event_stamp;
   logic signed [31:0]      req_live_ticks;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic signed [SUM_W-1:0] rsp_total_energy;
   logic [31:0]             rsp_out_stamp;
   logic signed [31:0]      rsp_out_live;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;

   event_total_tracker tracker = new();
   int                 hits_sent   = 0;
   int                 idle_cycles = 0;
   bit                 steady      = 1'b0;   // no gaps and no stalls while set

   quadrant_gain_match_event_sum dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Observe all three channels at the edge. Check results before noting the
   // new word so a result is never matched against an input of the same edge.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            tracker.check_total(rsp_total_energy, rsp_out_stamp, rsp_out_live);
         if (req_valid && !req_stall)
            tracker.note_hit(req_raw_energy, req_pos_x, req_pos_y, req_hit_index,
                             req_hit_count, req_event_stamp, req_live_ticks);
         if (csr_valid && csr_ready)
            tracker.write_coeff(csr_index, csr_data);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: hold stall for a random stretch, then take the next word.
   initial begin
      int hold;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         hold = steady ? 0 : $urandom_range(0, 16);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Give up when nothing has moved on any channel for too long.
   initial begin
      @(posedge clock);
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("quadrant_gain_match_event_sum: mismatch");
      $finish;
   end

   function automatic logic [15:0] draw_energy();
      case ($urandom_range(0, 7))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2, 3:    return 16'($urandom_range(0, 1023));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] draw_position();
      case ($urandom_range(0, 7))
         0:       return 16'd0;
         1:       return 16'h8000;
         2:       return 16'h7FFF;
         3:       return $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic coef_type draw_coeffs(coef_kind_type kind);
      coef_type    c;
      logic [62:0] raw;
      logic [20:0] part;
      case (kind)
         COEF_MAX:  c = {3{21'h0F_FFFF}};
         COEF_MIN:  c = {3{21'h10_0000}};
         COEF_ZERO: c = '0;
         COEF_UNITY: begin
            // near 1.0 gain with small offset and curvature
            c.c0 = 21'(int'($urandom_range(0, 8191)) - 4096);
            c.c1 = 21'(262144 + int'($urandom_range(0, 32767)) - 16384);
            c.c2 = 21'(int'($urandom_range(0, 8191)) - 4096);
         end
         COEF_WILD: c = 63'({$urandom, $urandom});
         default: begin
            // each field on its own: an extreme, zero or random
            for (int f = 0; f < 3; f++) begin
               case ($urandom_range(0, 3))
                  0:       part = 21'h0F_FFFF;
                  1:       part = 21'h10_0000;
                  2:       part = '0;
                  default: part = 21'($urandom);
               endcase
               raw[f*COEF_W +: COEF_W] = part;
            end
            c = raw;
         end
      endcase
      return c;
   endfunction

   // Send one interaction word. Keep valid high across back-to-back words.
   task automatic send_hit(input logic [15:0] energy, input logic [15:0] x,
                           input logic [15:0] y, input logic [3:0] index,
                           input logic [4:0] count, input logic [31:0] stamp,
                           input logic [31:0] live);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_raw_energy  <= energy;
      req_pos_x       <= x;
      req_pos_y       <= y;
      req_hit_index   <= index;
      req_hit_count   <= count;
      req_event_stamp <= stamp;
      req_live_ticks  <= live;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      hits_sent++;
   endtask

   // Mostly whole events with random content; some cut short, some noise words.
   task automatic send_event();
      int shape;
      int count;
      int stop;
      shape = $urandom_range(0, 9);
      if (shape == 9) begin
         send_hit(draw_energy(), draw_position(), draw_position(), 4'($urandom),
                  5'($urandom), $urandom, $urandom);
      end else begin
         count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_HITS)
                                             : $urandom_range(1, 4);
         stop = count;
         if (shape == 8 && count > 1) stop = $urandom_range(1, count - 1);
         for (int i = 0; i < stop; i++)
            send_hit(draw_energy(), draw_position(), draw_position(), 4'(i), 5'(count),
                     $urandom, $urandom);
      end
   endtask

   // Drop valid, wait for every awaited total, then let the pipeline empty.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.awaited_totals.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Load all four crystals for a phase, plus one write to an unused index.
   // Bit 63 is random; the block must drop it.
   task automatic program_crystals(input int phase);
      coef_kind_type kind;
      for (int i = 0; i < NUM_CRYSTALS; i++) begin
         case (phase)
            0:       kind = COEF_MAX;
            1:       kind = COEF_MIN;
            2:       kind = COEF_ZERO;
            3:       kind = COEF_UNITY;
            default: kind = coef_kind_type'($urandom_range(0, 5));
         endcase
         write_register(REG_CRYSTAL_FIRST + CSR_INDEX_W'(i),
                        {1'($urandom_range(0, 1)), draw_coeffs(kind)});
      end
      write_register(CSR_INDEX_W'($urandom_range(REG_UNUSED_FIRST, REG_LAST)),
                     {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   initial begin
      int phase_goal;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_raw_energy  <= '0;
      req_pos_x       <= '0;
      req_pos_y       <= '0;
      req_hit_index   <= '0;
      req_hit_count   <= '0;
      req_event_stamp <= '0;
      req_live_ticks  <= '0;
      csr_valid       <= 1'b0;
      csr_index       <= '0;
      csr_data        <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed words run on the identity gain loaded by reset.
      // Nonzero index straight out of reset: adds to the cleared sum, zero times.
      send_hit(16'd100, 16'd5, 16'd7, 4'd3, 5'd4, 32'hFFFF_FFFF, 32'h8000_0000);
      // Single-hit event with a zero x: emits at once with its own times.
      send_hit(16'hFFFF, 16'd0, 16'hFFFF, 4'd0, 5'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      // One word per quadrant, coordinate extremes.
      send_hit(16'd0, 16'h8000, 16'h8000, 4'd0, 5'd1, 32'h0000_0000, 32'h8000_0000);
      send_hit(16'd12345, 16'h7FFF, 16'h8000, 4'd0, 5'd1, 32'h1234_5678, 32'h0000_0000);
      send_hit(16'd40000, 16'hFFFF, 16'h7FFF, 4'd0, 5'd1, 32'h8000_0000, 32'hFFFF_FFFF);
      send_hit(16'd1, 16'd1, 16'd1, 4'd0, 5'd1, 32'h7FFF_FFFF, 32'h0000_0001);
      // Nine full-scale bypassed hits push the sum past its top.
      for (int i = 0; i < 9; i++)
         send_hit(16'hFFFF, 16'd0, 16'd0, 4'(i), 5'd9, $urandom, $urandom);
      // Count of zero, counts above the maximum and an index past the count:
      // the sum moves but nothing comes out.
      send_hit(16'd500, 16'd3, 16'hFFFD, 4'd0, 5'd0, 32'hAAAA_5555, 32'h5555_AAAA);
      send_hit(16'd7, 16'hFFF0, 16'h0010, 4'd15, 5'd31, $urandom, $urandom);
      send_hit(16'd9, 16'h0020, 16'h0020, 4'd0, 5'd17, $urandom, $urandom);
      send_hit(16'd11, 16'h8000, 16'h0001, 4'd5, 5'd3, $urandom, $urandom);
      // Last index of the largest event, reusing the held sum and times.
      send_hit(16'd2000, 16'hFFFF, 16'd1, 4'd15, 5'd16, $urandom, $urandom);

      // Random phases, each on its own coefficient setting.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         drain_results();
         program_crystals(phase);
         steady     = (phase == 3 || phase == 6);
         phase_goal = hits_sent + PHASE_HITS;
         while (hits_sent < phase_goal) send_event();
      end
      steady = 1'b0;

      drain_results();
      if (tracker.failures == 0 && tracker.awaited_totals.size() == 0)
         $display("quadrant_gain_match_event_sum: match");
      else
         $display("quadrant_gain_match_event_sum: mismatch");
      $finish;
   end

endmodule

// ----- quadrant_gain_match_event_sum.f -----
+incdir+hw/rtl
hw/rtl/qgmes_pkg.sv
hw/rtl/qgmes_coef_bank.sv
hw/rtl/qgmes_mac.sv
hw/rtl/quadrant_gain_match_event_sum.sv
hw/rtl/qgmes_checker.sv
test/tb.sv
